// ----- hdl/tdc_pkg.sv -----
// Shared types and constants for the time-of-day counter.
`default_nettype none
package tdc_pkg;

  localparam int SEC_PER_MIN   = 60;
  localparam int MIN_PER_HOUR  = 60;
  localparam int HOURS_PER_DAY = 24;
  localparam int HALF_DAY      = 12;

  localparam logic [3:0] REQ_TICK     = 4'd0;
  localparam logic [3:0] REQ_UNTICK   = 4'd1;
  localparam logic [3:0] REQ_SET_HOUR = 4'd2;
  localparam logic [3:0] REQ_SET_MIN  = 4'd3;
  localparam logic [3:0] REQ_SET_SEC  = 4'd4;
  localparam logic [3:0] REQ_ADD_SEC  = 4'd5;
  localparam logic [3:0] REQ_SUB_SEC  = 4'd6;
  localparam logic [3:0] REQ_ADJ_MIN  = 4'd7;
  localparam logic [3:0] REQ_ADJ_HOUR = 4'd8;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_STEP,
    OP_SET_HOUR,
    OP_SET_MIN,
    OP_SET_SEC
  } op_t;

  typedef enum logic [1:0] {
    UNIT_SEC,
    UNIT_MIN,
    UNIT_HOUR
  } unit_t;

  typedef struct packed {
    op_t        op;
    unit_t      unit;
    logic       sub;
    logic [5:0] set_val;
    logic       set_bad;
  } ctl_t;

endpackage
`default_nettype wire

// ----- hdl/time_of_day_counter.sv -----
// Top level: 24-hour time-of-day counter with set, tick and add/subtract operations.
// Throughput: one item per cycle unless out_valid is high and out_ready is low; the
// amount is split into second, minute and hour digits by three pipelined
// divide-by-constant units ahead of the time registers.
// Reset clears the pipeline, sets the time to 00:00:00 and format_24h to 1.
`default_nettype none
module time_of_day_counter #(
  parameter int AMOUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [3:0]             in_req_type,
  input  logic [AMOUNT_BITS-1:0] in_amount,
  input  logic                   in_subtract,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [4:0]             out_hours,
  output logic [5:0]             out_minutes_now,
  output logic [5:0]             out_seconds_now,
  output logic [4:0]             out_display_hour,
  output logic                   out_is_pm,
  output logic                   out_set_ignored,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_format_24h
);

  import tdc_pkg::*;

  localparam int W = AMOUNT_BITS;

  logic             adv;
  logic             fmt_r;
  logic             vld_r [0:6];
  ctl_t             ctl_r [0:6];
  logic [W-1:0]     amt_r [0:4];
  logic [5:0]       sd_r  [3:6];
  logic [5:0]       md_r  [5:6];

  ctl_t             ctl_in;
  logic [W-1:0]     x_in;
  logic [W-1:0]     q0, q1;
  logic [5:0]       r0, r1;
  logic [4:0]       r2;
  logic [W-1:0]     lvl1_x, lvl2_x;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_comb begin
    ctl_in.op      = OP_NONE;
    ctl_in.unit    = UNIT_SEC;
    ctl_in.sub     = 1'b0;
    ctl_in.set_val = in_amount[5:0];
    ctl_in.set_bad = 1'b0;
    x_in           = in_amount;
    case (in_req_type)
      REQ_TICK: begin
        ctl_in.op = OP_STEP;
        x_in      = W'(1);
      end
      REQ_UNTICK: begin
        ctl_in.op  = OP_STEP;
        ctl_in.sub = 1'b1;
        x_in       = W'(1);
      end
      REQ_SET_HOUR: begin
        ctl_in.op      = OP_SET_HOUR;
        ctl_in.set_bad = in_amount >= W'(HOURS_PER_DAY);
      end
      REQ_SET_MIN: begin
        ctl_in.op      = OP_SET_MIN;
        ctl_in.set_bad = in_amount >= W'(MIN_PER_HOUR);
      end
      REQ_SET_SEC: begin
        ctl_in.op      = OP_SET_SEC;
        ctl_in.set_bad = in_amount >= W'(SEC_PER_MIN);
      end
      REQ_ADD_SEC: begin
        ctl_in.op = OP_STEP;
      end
      REQ_SUB_SEC: begin
        ctl_in.op  = OP_STEP;
        ctl_in.sub = 1'b1;
      end
      REQ_ADJ_MIN: begin
        ctl_in.op   = OP_STEP;
        ctl_in.unit = UNIT_MIN;
        ctl_in.sub  = in_subtract;
      end
      REQ_ADJ_HOUR: begin
        ctl_in.op   = OP_STEP;
        ctl_in.unit = UNIT_HOUR;
        ctl_in.sub  = in_subtract;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= 1'b1;
    end else if (cfg_valid) begin
      fmt_r <= cfg_format_24h;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 7; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < 7; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r[0] <= ctl_in;
      amt_r[0] <= x_in;
      for (int i = 1; i < 7; i++) ctl_r[i] <= ctl_r[i-1];
      for (int i = 1; i < 5; i++) amt_r[i] <= amt_r[i-1];
      sd_r[3] <= r0;
      sd_r[4] <= sd_r[3];
      sd_r[5] <= sd_r[4];
      sd_r[6] <= sd_r[5];
      md_r[5] <= r1;
      md_r[6] <= md_r[5];
    end
  end

  assign lvl1_x = (ctl_r[2].unit == UNIT_MIN) ? amt_r[2] : q0;
  assign lvl2_x = (ctl_r[4].unit == UNIT_HOUR) ? amt_r[4] : q1;

  tdc_cdiv #(.W(W), .D(SEC_PER_MIN)) u_div_sec (
    .clk   (clk),
    .en    (adv),
    .x_i   (amt_r[0]),
    .quo_o (q0),
    .rem_o (r0)
  );

  tdc_cdiv #(.W(W), .D(MIN_PER_HOUR)) u_div_min (
    .clk   (clk),
    .en    (adv),
    .x_i   (lvl1_x),
    .quo_o (q1),
    .rem_o (r1)
  );

  tdc_cdiv #(.W(W), .D(HOURS_PER_DAY)) u_div_hour (
    .clk   (clk),
    .en    (adv),
    .x_i   (lvl2_x),
    .quo_o (),
    .rem_o (r2)
  );

  tdc_state u_state (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (adv),
    .vld_i          (vld_r[6]),
    .ctl_i          (ctl_r[6]),
    .sec_d_i        (sd_r[6]),
    .min_d_i        (md_r[6]),
    .hour_d_i       (r2),
    .format_24h_i   (fmt_r),
    .out_valid_o    (out_valid),
    .hours_o        (out_hours),
    .minutes_o      (out_minutes_now),
    .seconds_o      (out_seconds_now),
    .display_hour_o (out_display_hour),
    .is_pm_o        (out_is_pm),
    .set_ignored_o  (out_set_ignored)
  );

endmodule
`default_nettype wire

// ----- hdl/tdc_cdiv.sv -----
// Pipelined divide by a constant: reciprocal multiply, then one correction step.
`default_nettype none
module tdc_cdiv #(
  parameter int W = 16,
  parameter int D = 60,
  localparam int RW = $clog2(D)
) (
  input  logic          clk,
  input  logic          en,
  input  logic [W-1:0]  x_i,
  output logic [W-1:0]  quo_o,
  output logic [RW-1:0] rem_o
);

  localparam int K = W + 1;
  localparam longint unsigned MUL = (64'd1 << K) / D;
  localparam int MW = $clog2(MUL + 1);
  localparam int PW = W + MW;
  localparam int XW = W + 2;

  logic [PW-1:0] prod_r;
  logic [W-1:0]  x_r;
  logic [W-1:0]  quo_r;
  logic [RW-1:0] rem_r;

  logic [W-1:0]  qe;
  logic [XW-1:0] qd;
  logic [XW-1:0] r_raw;
  logic [RW:0]   rr;
  logic          over;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= {{MW{1'b0}}, x_i} * {{W{1'b0}}, MW'(MUL)};
      x_r    <= x_i;
    end
  end

  always_comb begin
    qe    = W'(prod_r[PW-1:K]);
    qd    = XW'(qe) * XW'(D);
    r_raw = XW'(x_r) - qd;
    rr    = r_raw[RW:0];
    over  = rr >= (RW+1)'(D);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= over ? qe + W'(1) : qe;
      rem_r <= over ? RW'(rr - (RW+1)'(D)) : RW'(rr);
    end
  end

  assign quo_o = quo_r;
  assign rem_o = rem_r;

endmodule
`default_nettype wire

// ----- hdl/tdc_state.sv -----
// Time registers, digit-wise add/subtract and set, display hour and result register.
`default_nettype none
module tdc_state (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  tdc_pkg::ctl_t ctl_i,
  input  logic [5:0]    sec_d_i,
  input  logic [5:0]    min_d_i,
  input  logic [4:0]    hour_d_i,
  input  logic          format_24h_i,
  output logic          out_valid_o,
  output logic [4:0]    hours_o,
  output logic [5:0]    minutes_o,
  output logic [5:0]    seconds_o,
  output logic [4:0]    display_hour_o,
  output logic          is_pm_o,
  output logic          set_ignored_o
);

  import tdc_pkg::*;

  logic [4:0] hour_r, hour_nxt;
  logic [5:0] min_r, min_nxt;
  logic [5:0] sec_r, sec_nxt;
  logic       out_valid_r;
  logic [4:0] hours_r, disp_r;
  logic [5:0] minutes_r, seconds_r;
  logic       is_pm_r, ign_r;

  logic [5:0] ds, dm;
  logic [6:0] s_t, m_t;
  logic [5:0] h_t;
  logic       c1, c2;
  logic [5:0] s_step, m_step;
  logic [4:0] h_step;
  logic [4:0] disp;

  always_comb begin
    ds = (ctl_i.unit == UNIT_SEC) ? sec_d_i : 6'd0;
    dm = (ctl_i.unit == UNIT_HOUR) ? 6'd0 : min_d_i;
    if (ctl_i.sub) begin
      s_t    = {1'b0, sec_r} - {1'b0, ds};
      c1     = s_t[6];
      s_step = c1 ? 6'(s_t + 7'(SEC_PER_MIN)) : s_t[5:0];
      m_t    = {1'b0, min_r} - {1'b0, dm} - {6'd0, c1};
      c2     = m_t[6];
      m_step = c2 ? 6'(m_t + 7'(MIN_PER_HOUR)) : m_t[5:0];
      h_t    = {1'b0, hour_r} - {1'b0, hour_d_i} - {5'd0, c2};
      h_step = h_t[5] ? 5'(h_t + 6'(HOURS_PER_DAY)) : h_t[4:0];
    end else begin
      s_t    = {1'b0, sec_r} + {1'b0, ds};
      c1     = s_t >= 7'(SEC_PER_MIN);
      s_step = c1 ? 6'(s_t - 7'(SEC_PER_MIN)) : s_t[5:0];
      m_t    = {1'b0, min_r} + {1'b0, dm} + {6'd0, c1};
      c2     = m_t >= 7'(MIN_PER_HOUR);
      m_step = c2 ? 6'(m_t - 7'(MIN_PER_HOUR)) : m_t[5:0];
      h_t    = {1'b0, hour_r} + {1'b0, hour_d_i} + {5'd0, c2};
      h_step = (h_t >= 6'(HOURS_PER_DAY)) ? 5'(h_t - 6'(HOURS_PER_DAY)) : h_t[4:0];
    end
  end

  always_comb begin
    hour_nxt = hour_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r;
    case (ctl_i.op)
      OP_STEP: begin
        hour_nxt = h_step;
        min_nxt  = m_step;
        sec_nxt  = s_step;
      end
      OP_SET_HOUR: begin
        if (!ctl_i.set_bad) hour_nxt = ctl_i.set_val[4:0];
      end
      OP_SET_MIN: begin
        if (!ctl_i.set_bad) min_nxt = ctl_i.set_val;
      end
      OP_SET_SEC: begin
        if (!ctl_i.set_bad) sec_nxt = ctl_i.set_val;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (format_24h_i) begin
      disp = hour_nxt;
    end else if (hour_nxt > 5'(HALF_DAY)) begin
      disp = hour_nxt - 5'(HALF_DAY);
    end else if (hour_nxt == 5'd0) begin
      disp = 5'(HALF_DAY);
    end else begin
      disp = hour_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_r      <= '0;
      min_r       <= '0;
      sec_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_i;
      if (vld_i) begin
        hour_r <= hour_nxt;
        min_r  <= min_nxt;
        sec_r  <= sec_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_i) begin
      hours_r   <= hour_nxt;
      minutes_r <= min_nxt;
      seconds_r <= sec_nxt;
      disp_r    <= disp;
      is_pm_r   <= hour_nxt >= 5'(HALF_DAY);
      ign_r     <= ctl_i.set_bad;
    end
  end

  assign out_valid_o    = out_valid_r;
  assign hours_o        = hours_r;
  assign minutes_o      = minutes_r;
  assign seconds_o      = seconds_r;
  assign display_hour_o = disp_r;
  assign is_pm_o        = is_pm_r;
  assign set_ignored_o  = ign_r;

endmodule
`default_nettype wire
